// ===== rtl/tcdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcdf_pkg
// Shared types, character codes and helpers for the tick count formatter.
// ----------------------------------------------------------------------------
package tcdf_pkg;

    localparam int TICK_W      = 20;
    localparam int CHAR_W      = 8;
    localparam int MIN_W       = 8;
    localparam int BCD_DIGITS  = 7;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int CNT_W       = 5;
    localparam int NUM_SLOTS   = 10;
    localparam int SLOT_W      = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // 6000 is 16 times 375. The minute count is ((ticks >> 4) * 89479) >> 25,
    // which is exact for every 16-bit value of ticks >> 4.
    localparam int PRE_SHIFT   = 4;
    localparam int QIN_W       = TICK_W - PRE_SHIFT;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 25;
    localparam int PROD_W      = QIN_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_375     = 17'd89479;
    localparam logic [CNT_W-1:0]   LAST_STEP     = CNT_W'(TICK_W - 1);
    localparam logic [SLOT_W-1:0]  LAST_SLOT     = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [TICK_W-1:0]  TICKS_PER_MIN = 20'd6000;

    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
    localparam logic [CHAR_W-1:0] CH_THREE = 8'h33;
    localparam logic [CHAR_W-1:0] CH_QUIT  = 8'h71;
    localparam logic [3:0]        DIGIT_HI = 4'h3;

    typedef struct packed {
        logic [CHAR_W-1:0] command_char;
        logic [TICK_W-1:0] tick_count;
    } tcdf_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
    } tcdf_out_t;

    typedef enum logic [1:0] {
        CMD_MMSS,
        CMD_POINT,
        CMD_RAW,
        CMD_QUIT
    } tcdf_cmd_t;

    typedef struct packed {
        tcdf_cmd_t         cmd;
        logic [TICK_W-1:0] ticks;
    } tcdf_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_XFER,
        ST_CONV,
        ST_EMIT
    } tcdf_state_t;

    // Shift-and-add-3 conversion of one byte into three BCD digits.
    function automatic logic [11:0] byte_to_bcd(input logic [MIN_W-1:0] value);
        logic [11:0]      bcd;
        logic [MIN_W-1:0] bin;
        bcd = '0;
        bin = value;
        for (int i = 0; i < MIN_W; i++) begin
            for (int d = 0; d < 3; d++) begin
                if (bcd[4*d +: 4] >= 4'd5) begin
                    bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                end
            end
            bcd = {bcd[10:0], bin[MIN_W-1]};
            bin = {bin[MIN_W-2:0], 1'b0};
        end
        return bcd;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tcdf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcdf_front
// Accepts command transactions, decodes them and holds the halted flag.
// ----------------------------------------------------------------------------
module tcdf_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  tcdf_pkg::tcdf_in_t       s_data,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output tcdf_pkg::tcdf_job_t      push_job
);
    import tcdf_pkg::*;

    logic      halted_reg;
    logic      halted_next;
    logic      known;
    tcdf_cmd_t cmd;

    always_comb begin
        known = 1'b1;
        cmd   = CMD_RAW;
        case (s_data.command_char)
            CH_ONE:   cmd = CMD_MMSS;
            CH_TWO:   cmd = CMD_POINT;
            CH_THREE: cmd = CMD_RAW;
            CH_QUIT:  cmd = CMD_QUIT;
            default:  known = 1'b0;
        endcase
    end

    // Unknown commands and everything after quit are taken and dropped.
    assign push_valid     = s_valid && known && !halted_reg;
    assign s_ready        = push_ready || !known || halted_reg;
    assign push_job.cmd   = cmd;
    assign push_job.ticks = s_data.tick_count;

    assign halted_next = halted_reg || (push_valid && push_ready && cmd == CMD_QUIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg <= 1'b0;
        end else begin
            halted_reg <= halted_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tcdf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcdf_queue
// Two-entry queue of decoded jobs between the front and back parts.
// ----------------------------------------------------------------------------
module tcdf_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  tcdf_pkg::tcdf_job_t      push_job,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output tcdf_pkg::tcdf_job_t      pop_job
);
    import tcdf_pkg::*;

    tcdf_job_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tcdf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcdf_back
// Divides, converts to decimal and streams the response characters.
// ----------------------------------------------------------------------------
module tcdf_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  tcdf_pkg::tcdf_job_t      pop_job,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tcdf_pkg::tcdf_out_t      m_data
);
    import tcdf_pkg::*;

    tcdf_state_t       state_reg;
    tcdf_state_t       state_next;
    tcdf_cmd_t         cmd_reg;
    tcdf_cmd_t         cmd_next;
    logic [TICK_W-1:0] shift_reg;
    logic [TICK_W-1:0] shift_next;
    logic [BCD_W-1:0]  bcd_reg;
    logic [BCD_W-1:0]  bcd_next;
    logic [MIN_W-1:0]  min_reg;
    logic [MIN_W-1:0]  min_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    tcdf_out_t         m_data_reg;
    tcdf_out_t         m_data_next;

    logic              out_free;
    logic              load;
    logic [PROD_W-1:0] div_prod;
    logic [TICK_W-1:0] min_ticks;
    logic [TICK_W-1:0] rem_calc;
    logic [BCD_W-1:0]  bcd_adj;
    logic [11:0]       min_bcd;
    logic [BCD_DIGITS-1:0] nz;
    logic [CHAR_W-1:0] slot_char [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] emask;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Minute count by reciprocal multiplication, then the ticks left over.
    assign div_prod  = PROD_W'(shift_reg[TICK_W-1:PRE_SHIFT]) * PROD_W'(RECIP_375);
    assign min_ticks = TICK_W'(min_reg) * TICKS_PER_MIN;
    assign rem_calc  = shift_reg - min_ticks;

    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                bcd_reg[4*d +: 4] + 4'd3 : bcd_reg[4*d +: 4];
        end
    end

    // Place tests: a place is shown when any digit at or above it is nonzero.
    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int k = BCD_DIGITS - 1; k >= 0; k--) begin
            acc   = acc || (bcd_reg[4*k +: 4] != 4'd0);
            nz[k] = acc;
        end
    end

    assign min_bcd = byte_to_bcd(min_reg);

    // Character template of the response, one slot per possible character.
    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_char[s] = {DIGIT_HI, 4'd0};
        end
        emask        = '0;
        slot_char[0] = CH_CR;
        slot_char[1] = CH_LF;
        slot_char[2] = CH_CR;
        emask[1:0]   = 2'b11;
        emask[2]     = cmd_reg != CMD_QUIT;
        case (cmd_reg)
            CMD_MMSS: begin
                slot_char[3] = {DIGIT_HI, min_bcd[7:4]};
                emask[3]     = min_reg >= MIN_W'(10);
                slot_char[4] = {DIGIT_HI, min_bcd[3:0]};
                emask[4]     = min_reg != '0;
                slot_char[5] = CH_COLON;
                emask[5]     = 1'b1;
                slot_char[6] = {DIGIT_HI, bcd_reg[15:12]};
                emask[6]     = bcd_reg[15:12] != 4'd0;
                slot_char[7] = {DIGIT_HI, bcd_reg[11:8]};
                emask[7]     = bcd_reg[15:8] != 8'd0;
            end
            CMD_POINT: begin
                for (int k = 2; k < 6; k++) begin
                    slot_char[8-k] = {DIGIT_HI, bcd_reg[4*k +: 4]};
                    emask[8-k]     = nz[k];
                end
                slot_char[7] = CH_POINT;
                emask[7]     = 1'b1;
                for (int k = 0; k < 2; k++) begin
                    slot_char[9-k] = {DIGIT_HI, bcd_reg[4*k +: 4]};
                    emask[9-k]     = nz[k];
                end
            end
            CMD_RAW: begin
                for (int k = 0; k < 6; k++) begin
                    slot_char[8-k] = {DIGIT_HI, bcd_reg[4*k +: 4]};
                    emask[8-k]     = nz[k];
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    case (pop_job.cmd)
                        CMD_MMSS: state_next = ST_DIV;
                        CMD_QUIT: state_next = ST_EMIT;
                        default:  state_next = ST_CONV;
                    endcase
                end
            end
            ST_DIV:  state_next = ST_XFER;
            ST_XFER: state_next = ST_CONV;
            ST_CONV: begin
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && slot_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        pop_ready  = 1'b0;
        cmd_next   = cmd_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        min_next   = min_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    cmd_next   = pop_job.cmd;
                    shift_next = pop_job.ticks;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    slot_next  = '0;
                end
            end
            ST_DIV: begin
                min_next = div_prod[RECIP_SHIFT +: MIN_W];
            end
            ST_XFER: begin
                // Convert the ticks left over after the whole minutes.
                shift_next = rem_calc;
                bcd_next   = '0;
                cnt_next   = '0;
            end
            ST_CONV: begin
                bcd_next   = {bcd_adj[BCD_W-2:0], shift_reg[TICK_W-1]};
                shift_next = {shift_reg[TICK_W-2:0], 1'b0};
                cnt_next   = (cnt_reg == LAST_STEP) ? '0 : cnt_reg + CNT_W'(1);
            end
            ST_EMIT: begin
                if (out_free) begin
                    load      = emask[slot_reg];
                    slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = load || (m_valid_reg && !m_ready);
        m_data_next  = m_data_reg;
        if (load) begin
            m_data_next.out_char  = slot_char[slot_reg];
            m_data_next.last_char = (emask >> slot_reg) == NUM_SLOTS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        shift_reg  <= shift_next;
        bcd_reg    <= bcd_next;
        min_reg    <= min_next;
        m_data_reg <= m_data_next;
    end

    a_rem_below_divisor : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_XFER) |-> (min_ticks <= shift_reg && rem_calc < TICKS_PER_MIN))
        else $error("leftover ticks are not below one minute");

    a_step_count_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> (cnt_reg <= LAST_STEP))
        else $error("iteration counter ran past the last step");

    a_idle_after_emit : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && slot_reg == LAST_SLOT)
        |=> (state_reg == ST_IDLE && slot_reg == '0))
        else $error("emit phase did not end after the last slot");

endmodule
`default_nettype wire

// ===== rtl/tick_count_decimal_formatter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tick_count_decimal_formatter
// Answers command characters with a text line built from a tick count.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                               Handshake
//   s_       in         command_char[8], tick_count[20]       s_valid / s_ready
//   m_       out        out_char[8], last_char[1]             m_valid / m_ready
//
// The front part decodes each command transaction in its accept cycle.
// Unknown characters, and every transaction after a quit command, are
// accepted and dropped. Known commands go into a two-entry job queue.
// For '1' the back part loads the job, finds the minutes by a reciprocal
// multiply, takes the leftover ticks, runs a 20-step binary to BCD
// conversion and steps through ten character slots. '2' and '3' skip the
// minute steps, and 'q' goes from the load straight to the slots.
// The character slots share the output register; a stalled m_ready holds
// the back part while the front keeps filling the queue. Reset clears the
// halted flag, the queue and the back part's control state.
//
// ----------------------------------------------------------------------------
module tick_count_decimal_formatter (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  tcdf_pkg::tcdf_in_t       s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tcdf_pkg::tcdf_out_t      m_data
);
    import tcdf_pkg::*;

    // Front to queue.
    logic      push_valid;
    logic      push_ready;
    tcdf_job_t push_job;

    // Queue to back.
    logic      pop_valid;
    logic      pop_ready;
    tcdf_job_t pop_job;

    // Decodes commands and tracks whether a quit has been seen.
    tcdf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Lets a new command be taken while a response is still streaming out.
    tcdf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Works out the decimal digits and sends one transaction per character.
    tcdf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ===== bench/tb_tick_count_decimal_formatter.sv =====
// ----------------------------------------------------------------------------
// tb_tick_count_decimal_formatter
// Self-checking regression for the tick count decimal formatter.
// ----------------------------------------------------------------------------
//
// Command transactions come from a queue of pending items that the stimulus
// process fills. A clocked driver offers them on the s_ channel. A clocked
// monitor predicts the text line for every accepted command. It compares
// every accepted m_ transaction with the oldest predicted character.
// The run has four phases of idling: none, sender only, receiver only, and
// both. It also has one long receiver hold-off that backs the block up into
// its input. The quit command comes last, because it halts the block for the
// rest of the run.
//
// ----------------------------------------------------------------------------
module tb_tick_count_decimal_formatter;

    import tcdf_pkg::*;

    // ASCII zero; a digit character is this plus the digit value.
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;

    // Command characters that the block must drop without a response.
    localparam logic [CHAR_W-1:0] BOGUS_NUL      = 8'h00;
    localparam logic [CHAR_W-1:0] BOGUS_ALL_ONES = 8'hFF;
    localparam logic [CHAR_W-1:0] BOGUS_LETTER   = 8'h78;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Number of cycles for the long receiver hold-off. It must stay well
    // below the watchdog limit, because nothing is accepted while the block
    // is backed up.
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TIME  = 200;
    localparam int KNOWN_PER_PHASE = 55;
    localparam int MAX_REPORTS  = 10;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tcdf_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tcdf_out_t m_data;

    tick_count_decimal_formatter DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Commands that wait to be offered, and the characters that the block
    // still owes us, oldest first.
    tcdf_in_t  pending_cmds[$];
    tcdf_out_t expected_chars[$];

    // The predictor's copy of the halted flag. Reset happens only once.
    bit        line_halted = 1'b0;

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    bit        long_hold_req  = 1'b0;
    int        hold_left      = 0;
    int        idle_cycles    = 0;
    int        mismatches     = 0;
    tcdf_out_t want_char;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void push_char(logic [CHAR_W-1:0] c);
        tcdf_out_t item;
        item.out_char  = c;
        item.last_char = 1'b0;
        expected_chars.push_back(item);
    endfunction

    // Sends the places from weight top down to one. A place's digit comes
    // from the value modulo ten times its weight, but it is sent only when
    // the full value reaches that weight. This is why 100 minutes prints
    // "00" and why counts above six places still print six digits.
    function automatic void push_places(int unsigned full, int unsigned top,
                                        bit point_before_tens);
        for (int unsigned w = top; w > 0; w = w / 10) begin
            if (point_before_tens && w == 10) begin
                push_char(CH_POINT);
            end
            if (full >= w) begin
                push_char(CH_ZERO + CHAR_W'((full % (w * 10)) / w));
            end
        end
    endfunction

    function automatic void format_response(logic [CHAR_W-1:0] cmd,
                                            logic [TICK_W-1:0] ticks);
        int unsigned count;
        int unsigned secs;
        tcdf_out_t   tail;
        count = int'(ticks);
        secs  = count / 100;
        if (line_halted) begin
            return;
        end
        if (cmd != CH_ONE && cmd != CH_TWO && cmd != CH_THREE && cmd != CH_QUIT) begin
            return;
        end
        push_char(CH_CR);
        push_char(CH_LF);
        if (cmd == CH_QUIT) begin
            line_halted = 1'b1;
        end else begin
            push_char(CH_CR);
            if (cmd == CH_ONE) begin
                push_places(secs / 60, 10, 1'b0);
                push_char(CH_COLON);
                push_places(secs % 60, 10, 1'b0);
            end else begin
                push_places(count, 100000, cmd == CH_TWO);
            end
        end
        tail = expected_chars.pop_back();
        tail.last_char = 1'b1;
        expected_chars.push_back(tail);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the pending commands. It idles at random at the rate of
    // the current phase, and only while it is not holding a transaction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_data  <= pending_cmds.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off. The hold-off is
    // counted here once the stimulus process asks for it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (long_hold_req) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks the output first and then predicts from the input, so
    // that a stray character can never match a line predicted at that edge.
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                              m_data.out_char, m_data.last_char));
                end else begin
                    want_char = expected_chars.pop_front();
                    if (m_data.out_char !== want_char.out_char) begin
                        report_mismatch($sformatf("out_char expected 0x%02h got 0x%02h",
                                                  want_char.out_char, m_data.out_char));
                    end
                    if (m_data.last_char !== want_char.last_char) begin
                        report_mismatch($sformatf("last_char expected %0b got %0b on 0x%02h",
                                                  want_char.last_char, m_data.last_char,
                                                  want_char.out_char));
                    end
                end
            end
            if (s_valid && s_ready) begin
                format_response(s_data.command_char, s_data.tick_count);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // The watchdog ends the run when nothing has moved for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(negedge aclk);
        end
        $display("tick_count_decimal_formatter regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_cmd(logic [CHAR_W-1:0] cmd, logic [TICK_W-1:0] ticks);
        pending_cmds.push_back(tcdf_in_t'{command_char: cmd, tick_count: ticks});
    endtask

    // Tick counts are biased toward the boundaries that matter: small values,
    // whole seconds and minutes, powers of ten, and counts above six places.
    function automatic logic [TICK_W-1:0] pick_ticks();
        int unsigned p;
        p = 1;
        case ($urandom_range(0, 9))
            0: return TICK_W'($urandom_range(0, 199));
            1: return TICK_W'($urandom_range(1, 174) * 6000 - 1 + $urandom_range(0, 2));
            2: return TICK_W'($urandom_range(1, 9999) * 100 - 1 + $urandom_range(0, 2));
            3: begin
                repeat ($urandom_range(0, 5)) p = p * 10;
                return TICK_W'(p - 1 + $urandom_range(0, 1));
            end
            4: return TICK_W'($urandom_range(1000000, int'(TICK_MAX)));
            default: return TICK_W'($urandom_range(0, 999999));
        endcase
    endfunction

    // Queues a number of formatting commands with random content. About one
    // item in five is a character the block must drop; those come on top.
    task automatic queue_random(int known);
        int               made;
        logic [CHAR_W-1:0] c;
        made = 0;
        while (made < known) begin
            if ($urandom_range(0, 4) == 0) begin
                do begin
                    c = CHAR_W'($urandom_range(0, 255));
                end while (c == CH_ONE || c == CH_TWO || c == CH_THREE || c == CH_QUIT);
                queue_cmd(c, TICK_W'($urandom));
            end else begin
                case ($urandom_range(0, 2))
                    0: c = CH_ONE;
                    1: c = CH_TWO;
                    default: c = CH_THREE;
                endcase
                queue_cmd(c, pick_ticks());
                made++;
            end
        end
    endtask

    // The sender pauses here until every command has gone out and every
    // predicted character has come back.
    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || s_valid || expected_chars.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic run_phase(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(KNOWN_PER_PHASE);
        wait_quiet();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed lines: field extremes, rollovers of seconds and minutes,
        // the minute count past 99, counts above six places, and the point
        // with no digits around it.
        queue_cmd(CH_ONE, TICK_W'(0));
        queue_cmd(CH_ONE, TICK_W'(99));
        queue_cmd(CH_ONE, TICK_W'(100));
        queue_cmd(CH_ONE, TICK_W'(5999));
        queue_cmd(CH_ONE, TICK_W'(6000));
        queue_cmd(CH_ONE, TICK_W'(59999));
        queue_cmd(CH_ONE, TICK_W'(60000));
        queue_cmd(CH_ONE, TICK_W'(599999));
        queue_cmd(CH_ONE, TICK_W'(600000));
        queue_cmd(CH_ONE, TICK_MAX);
        queue_cmd(CH_TWO, TICK_W'(0));
        queue_cmd(CH_TWO, TICK_W'(5));
        queue_cmd(CH_TWO, TICK_W'(10));
        queue_cmd(CH_TWO, TICK_W'(123456));
        queue_cmd(CH_TWO, TICK_W'(999999));
        queue_cmd(CH_TWO, TICK_W'(1000000));
        queue_cmd(CH_TWO, TICK_MAX);
        queue_cmd(CH_THREE, TICK_W'(0));
        queue_cmd(CH_THREE, TICK_W'(9));
        queue_cmd(CH_THREE, TICK_W'(100000));
        queue_cmd(CH_THREE, TICK_W'(999999));
        queue_cmd(CH_THREE, TICK_MAX);
        queue_cmd(BOGUS_NUL, TICK_W'(0));
        queue_cmd(BOGUS_ALL_ONES, TICK_MAX);
        queue_cmd(BOGUS_LETTER, TICK_W'(4242));

        // While the sender keeps offering at full rate, the receiver holds
        // off for a long stretch. The job queue fills up and s_ready drops.
        long_hold_req = 1'b1;
        @(negedge aclk);
        long_hold_req = 1'b0;
        run_phase(0, 0);

        run_phase(58, 0);
        run_phase(0, 58);

        // The last phase ends with the quit command. Every command after it,
        // known or not, must be dropped without a response.
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        queue_random(KNOWN_PER_PHASE);
        queue_cmd(CH_QUIT, pick_ticks());
        queue_cmd(CH_ONE, TICK_W'(60000));
        queue_cmd(CH_TWO, TICK_W'(123456));
        queue_cmd(BOGUS_LETTER, TICK_W'(0));
        queue_cmd(CH_THREE, TICK_MAX);
        queue_cmd(CH_QUIT, TICK_W'(0));
        wait_quiet();

        // Give a late stray character time to show up before the verdict.
        repeat (SETTLE_TIME) @(negedge aclk);

        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("tick_count_decimal_formatter regression: pass");
        end else begin
            $display("tick_count_decimal_formatter regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tcdf_pkg.sv
rtl/tcdf_front.sv
rtl/tcdf_queue.sv
rtl/tcdf_back.sv
rtl/tick_count_decimal_formatter.sv
bench/tb_tick_count_decimal_formatter.sv
